### hdl/dsst_pkg.sv
// ----------------------------------------------------------------------------
// dsst_pkg
// Shared widths, codes, reset values and types for the two-axis deadband
// servo tracker.
// ----------------------------------------------------------------------------
package dsst_pkg;

    localparam int ERR_W      = 10;
    localparam int TH_W       = 9;
    localparam int GAIN_W     = 8;
    localparam int CNT_W      = 6;
    localparam int POS_W      = 19;
    localparam int PX_W       = 13;
    localparam int PY_W       = 12;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_X_FAR_TH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FAR_TH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_FAR_G   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_NEAR_G  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FAR_G   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Y_NEAR_G  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd7;

    localparam logic [TH_W-1:0]   RST_X_FAR_TH = 9'd50;
    localparam logic [TH_W-1:0]   RST_Y_FAR_TH = 9'd30;
    localparam logic [TH_W-1:0]   RST_DEADBAND = 9'd5;
    localparam logic [GAIN_W-1:0] RST_X_FAR_G  = 8'd5;
    localparam logic [GAIN_W-1:0] RST_X_NEAR_G = 8'd3;
    localparam logic [GAIN_W-1:0] RST_Y_FAR_G  = 8'd3;
    localparam logic [GAIN_W-1:0] RST_Y_NEAR_G = 8'd1;
    localparam logic [CNT_W-1:0]  RST_SETTLE   = 6'd20;

    localparam int PAN_RESET  = 0;
    localparam int TILT_RESET = 1000;

    localparam logic [STATUS_W-1:0] STATUS_ADJUST   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CENTERED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    typedef struct packed {
        logic centered;
        logic in_window;
    } lane_stat_t;

    typedef struct packed {
        logic [PX_W-1:0]     pos_x;
        logic [PY_W-1:0]     pos_y;
        logic [STATUS_W-1:0] status;
        logic                fire;
    } result_t;

endpackage

### hdl/dsst_axis_lane.sv
// ----------------------------------------------------------------------------
// dsst_axis_lane
// One axis: error magnitude, gain schedule, position update and clamp.
// Holds the axis position.
// ----------------------------------------------------------------------------
module dsst_axis_lane #(
    parameter int ERR_WINDOW = 112,
    parameter int POS_LOW    = -3600,
    parameter int POS_HIGH   = 3600,
    parameter int POS_RESET  = 0,
    parameter int OUT_W      = 13
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              apply,
    input  logic signed [dsst_pkg::ERR_W-1:0] err,
    input  logic [dsst_pkg::TH_W-1:0]         far_th,
    input  logic [dsst_pkg::TH_W-1:0]         deadband,
    input  logic [dsst_pkg::GAIN_W-1:0]       far_gain,
    input  logic [dsst_pkg::GAIN_W-1:0]       near_gain,
    output dsst_pkg::lane_stat_t              stat,
    output logic [OUT_W-1:0]                  pos_out
);

    localparam int EW = dsst_pkg::ERR_W;
    localparam int PW = dsst_pkg::POS_W;
    localparam int GW = dsst_pkg::GAIN_W;
    localparam logic [EW-1:0]        WIN = EW'(ERR_WINDOW);
    localparam logic signed [PW-1:0] LO  = PW'(POS_LOW);
    localparam logic signed [PW-1:0] HI  = PW'(POS_HIGH);
    localparam logic signed [PW-1:0] RST = PW'(POS_RESET);

    logic signed [PW-1:0] pos_reg;
    logic signed [PW-1:0] pos_next;
    logic [EW-1:0]        mag;
    logic                 is_far;
    logic                 is_near;
    logic [GW-1:0]        gain;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] clamped;

    always_comb begin
        mag     = err[EW-1] ? EW'(-err) : EW'(err);
        is_far  = mag > {1'b0, far_th};
        is_near = mag > {1'b0, deadband};
        gain    = is_far ? far_gain : (is_near ? near_gain : '0);
        prod    = $signed({{(PW-EW){err[EW-1]}}, err})
                * $signed({{(PW-GW){1'b0}}, gain});
        sum     = pos_reg - prod;
        if (sum > HI) begin
            clamped = HI;
        end else if (sum < LO) begin
            clamped = LO;
        end else begin
            clamped = sum;
        end
        pos_next = apply ? clamped : pos_reg;
    end

    assign stat.centered  = !is_far && !is_near;
    assign stat.in_window = mag <= WIN;
    assign pos_out        = pos_next[OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= RST;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

### hdl/dsst_merge.sv
// ----------------------------------------------------------------------------
// dsst_merge
// Combines the lane results: status, settle counter, fire pulse, and the
// output register with a skid stage.
// ----------------------------------------------------------------------------
module dsst_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  dsst_pkg::lane_stat_t                 stat_x,
    input  dsst_pkg::lane_stat_t                 stat_y,
    input  logic [dsst_pkg::CNT_W-1:0]           settle_target,
    input  logic [dsst_pkg::PX_W-1:0]            pos_x,
    input  logic [dsst_pkg::PY_W-1:0]            pos_y,
    output logic                                 s_ready,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output dsst_pkg::result_t                    m_res
);

    localparam int CW = dsst_pkg::CNT_W;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     count_mid;
    logic              in_range;
    logic              fire;
    dsst_pkg::result_t res_new;
    dsst_pkg::result_t out_reg;
    dsst_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              out_free;

    always_comb begin
        in_range = stat_x.in_window && stat_y.in_window;
        if (!in_range) begin
            count_mid = count_reg;
        end else if (stat_x.centered && stat_y.centered) begin
            count_mid = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        end else begin
            count_mid = '0;
        end
        fire       = count_mid >= settle_target;
        count_next = fire ? '0 : count_mid;

        res_new.pos_x = pos_x;
        res_new.pos_y = pos_y;
        res_new.fire  = fire;
        if (!in_range) begin
            res_new.status = dsst_pkg::STATUS_RANGE;
        end else if (stat_x.centered && stat_y.centered) begin
            res_new.status = dsst_pkg::STATUS_CENTERED;
        end else begin
            res_new.status = dsst_pkg::STATUS_ADJUST;
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (out_free) begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res_new;
            end
        end else if (accept) begin
            skid_reg <= res_new;
        end
    end

endmodule

### hdl/two_axis_deadband_servo_tracker_top.sv
// ----------------------------------------------------------------------------
// two_axis_deadband_servo_tracker_top
// Two-axis gain-scheduled deadband tracker with settle counter and fire pulse.
//
// Input channel (s_): one item carries the signed pixel errors s_err_x and
// s_err_y. Result channel (m_): one item per input item with the pan and
// tilt positions after the update, a status code and the fire pulse.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index at the
// clock edge; write only while no item is in flight.
// The result is registered in the output register, or in the skid register
// while the output stalls. Throughput: one item per cycle while s_ready is
// high. Each axis lane does its compare, one multiply, subtract and clamp in
// the cycle of acceptance, since the next item uses the updated position.
// Stall: a two-entry output stage (register plus skid) holds results; the
// input keeps accepting until both entries are full.
// Reset: positions return to pan 0 and tilt 1000, the settle count clears,
// all configuration registers take their default values, the output empties.
// ----------------------------------------------------------------------------
module two_axis_deadband_servo_tracker_top #(
    parameter int PAN_LIMIT    = 3600,
    parameter int TILT_HIGH    = 2000,
    parameter int TILT_LOW     = -1000,
    parameter int ERROR_WINDOW = 112
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [dsst_pkg::ERR_W-1:0]      s_err_x,
    input  logic signed [dsst_pkg::ERR_W-1:0]      s_err_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [dsst_pkg::PX_W-1:0]       m_pos_x,
    output logic signed [dsst_pkg::PY_W-1:0]       m_pos_y,
    output logic [dsst_pkg::STATUS_W-1:0]          m_status,
    output logic                                   m_fire,
    input  logic                                   cfg_wr_en,
    input  logic [dsst_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dsst_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    logic [dsst_pkg::TH_W-1:0]   x_far_th_reg;
    logic [dsst_pkg::TH_W-1:0]   y_far_th_reg;
    logic [dsst_pkg::TH_W-1:0]   deadband_reg;
    logic [dsst_pkg::GAIN_W-1:0] x_far_g_reg;
    logic [dsst_pkg::GAIN_W-1:0] x_near_g_reg;
    logic [dsst_pkg::GAIN_W-1:0] y_far_g_reg;
    logic [dsst_pkg::GAIN_W-1:0] y_near_g_reg;
    logic [dsst_pkg::CNT_W-1:0]  settle_reg;

    logic                        accept;
    logic                        apply;
    dsst_pkg::lane_stat_t        stat_x;
    dsst_pkg::lane_stat_t        stat_y;
    logic [dsst_pkg::PX_W-1:0]   pos_x;
    logic [dsst_pkg::PY_W-1:0]   pos_y;
    dsst_pkg::result_t           res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_far_th_reg <= dsst_pkg::RST_X_FAR_TH;
            y_far_th_reg <= dsst_pkg::RST_Y_FAR_TH;
            deadband_reg <= dsst_pkg::RST_DEADBAND;
            x_far_g_reg  <= dsst_pkg::RST_X_FAR_G;
            x_near_g_reg <= dsst_pkg::RST_X_NEAR_G;
            y_far_g_reg  <= dsst_pkg::RST_Y_FAR_G;
            y_near_g_reg <= dsst_pkg::RST_Y_NEAR_G;
            settle_reg   <= dsst_pkg::RST_SETTLE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dsst_pkg::REG_X_FAR_TH: x_far_th_reg <= cfg_wdata;
                dsst_pkg::REG_Y_FAR_TH: y_far_th_reg <= cfg_wdata;
                dsst_pkg::REG_DEADBAND: deadband_reg <= cfg_wdata;
                dsst_pkg::REG_X_FAR_G:  x_far_g_reg  <= cfg_wdata[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_X_NEAR_G: x_near_g_reg <= cfg_wdata[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_Y_FAR_G:  y_far_g_reg  <= cfg_wdata[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_Y_NEAR_G: y_near_g_reg <= cfg_wdata[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_SETTLE:   settle_reg   <= cfg_wdata[dsst_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept = s_valid && s_ready;
    assign apply  = accept && stat_x.in_window && stat_y.in_window;

    dsst_axis_lane #(
        .ERR_WINDOW (ERROR_WINDOW),
        .POS_LOW    (-PAN_LIMIT),
        .POS_HIGH   (PAN_LIMIT),
        .POS_RESET  (dsst_pkg::PAN_RESET),
        .OUT_W      (dsst_pkg::PX_W)
    ) u_lane_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .apply     (apply),
        .err       (s_err_x),
        .far_th    (x_far_th_reg),
        .deadband  (deadband_reg),
        .far_gain  (x_far_g_reg),
        .near_gain (x_near_g_reg),
        .stat      (stat_x),
        .pos_out   (pos_x)
    );

    dsst_axis_lane #(
        .ERR_WINDOW (ERROR_WINDOW),
        .POS_LOW    (TILT_LOW),
        .POS_HIGH   (TILT_HIGH),
        .POS_RESET  (dsst_pkg::TILT_RESET),
        .OUT_W      (dsst_pkg::PY_W)
    ) u_lane_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .apply     (apply),
        .err       (s_err_y),
        .far_th    (y_far_th_reg),
        .deadband  (deadband_reg),
        .far_gain  (y_far_g_reg),
        .near_gain (y_near_g_reg),
        .stat      (stat_y),
        .pos_out   (pos_y)
    );

    dsst_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .stat_x        (stat_x),
        .stat_y        (stat_y),
        .settle_target (settle_reg),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_res         (res)
    );

    assign m_pos_x  = res.pos_x;
    assign m_pos_y  = res.pos_y;
    assign m_status = res.status;
    assign m_fire   = res.fire;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-axis deadband servo tracker. Directed items
// hit the window edges, the far/near/centered bands, the clamps and the fire
// pulse. Several register settings then run random error traffic, mostly
// centered runs that build up the settle count. A scoreboard predicts every
// result and checks it as it leaves the block, under random idling on both
// sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PAN_LIM     = 3600;
    localparam int TILT_HI     = 2000;
    localparam int TILT_LO     = -1000;
    localparam int ERR_WIN     = 112;
    localparam int CNT_MAX     = (1 << dsst_pkg::CNT_W) - 1;
    localparam int PHASE_ITEMS = 118;
    localparam int MAX_CYCLES  = 200000;

    typedef enum int {ERR_IN_DB, ERR_IN_WIN, ERR_FULL} err_kind_t;

    class servo_track_scoreboard;
        logic [dsst_pkg::TH_W-1:0]   x_far_th, y_far_th, dead_band;
        logic [dsst_pkg::GAIN_W-1:0] x_far_g, x_near_g, y_far_g, y_near_g;
        logic [dsst_pkg::CNT_W-1:0]  settle_tgt;
        int                          pan_pos, tilt_pos;
        int unsigned                 settle_cnt;
        dsst_pkg::result_t           pending_results[$];
        int                          mismatches;

        function new();
            x_far_th   = dsst_pkg::RST_X_FAR_TH;
            y_far_th   = dsst_pkg::RST_Y_FAR_TH;
            dead_band  = dsst_pkg::RST_DEADBAND;
            x_far_g    = dsst_pkg::RST_X_FAR_G;
            x_near_g   = dsst_pkg::RST_X_NEAR_G;
            y_far_g    = dsst_pkg::RST_Y_FAR_G;
            y_near_g   = dsst_pkg::RST_Y_NEAR_G;
            settle_tgt = dsst_pkg::RST_SETTLE;
            pan_pos    = dsst_pkg::PAN_RESET;
            tilt_pos   = dsst_pkg::TILT_RESET;
            settle_cnt = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [dsst_pkg::CFG_IDX_W-1:0] idx,
                                logic [dsst_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                dsst_pkg::REG_X_FAR_TH: x_far_th   = val;
                dsst_pkg::REG_Y_FAR_TH: y_far_th   = val;
                dsst_pkg::REG_DEADBAND: dead_band  = val;
                dsst_pkg::REG_X_FAR_G:  x_far_g    = val[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_X_NEAR_G: x_near_g   = val[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_Y_FAR_G:  y_far_g    = val[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_Y_NEAR_G: y_near_g   = val[dsst_pkg::GAIN_W-1:0];
                dsst_pkg::REG_SETTLE:   settle_tgt = val[dsst_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // far band is tested first; returns 1 when the axis is centered
        function bit axis_move(int err, int far_th, int far_g, int near_g, inout int pos);
            int m;
            m = (err < 0) ? -err : err;
            if (m > far_th) begin
                pos = pos - err * far_g;
                return 1'b0;
            end
            if (m > int'(dead_band)) begin
                pos = pos - err * near_g;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_item(logic signed [dsst_pkg::ERR_W-1:0] ex,
                                logic signed [dsst_pkg::ERR_W-1:0] ey);
            int                xe, ye;
            bit                cx, cy;
            dsst_pkg::result_t want;
            xe = int'(ex);
            ye = int'(ey);
            if (xe > ERR_WIN || xe < -ERR_WIN || ye > ERR_WIN || ye < -ERR_WIN) begin
                want.status = dsst_pkg::STATUS_RANGE;
            end else begin
                cx = axis_move(xe, int'(x_far_th), int'(x_far_g), int'(x_near_g), pan_pos);
                cy = axis_move(ye, int'(y_far_th), int'(y_far_g), int'(y_near_g), tilt_pos);
                if (pan_pos > PAN_LIM) pan_pos = PAN_LIM;
                if (pan_pos < -PAN_LIM) pan_pos = -PAN_LIM;
                if (tilt_pos > TILT_HI) tilt_pos = TILT_HI;
                if (tilt_pos < TILT_LO) tilt_pos = TILT_LO;
                if (cx && cy) begin
                    want.status = dsst_pkg::STATUS_CENTERED;
                    if (settle_cnt < CNT_MAX) settle_cnt++;
                end else begin
                    want.status = dsst_pkg::STATUS_ADJUST;
                    settle_cnt = 0;
                end
            end
            want.fire = 1'b0;
            if (settle_cnt >= 32'(settle_tgt)) begin
                want.fire = 1'b1;
                settle_cnt = 0;
            end
            want.pos_x = pan_pos[dsst_pkg::PX_W-1:0];
            want.pos_y = tilt_pos[dsst_pkg::PY_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(dsst_pkg::result_t got);
            dsst_pkg::result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result pos_x=%0d pos_y=%0d status=%0d fire=%0d",
                         $time, $signed(got.pos_x), $signed(got.pos_y), got.status, got.fire);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.pos_x !== want.pos_x) begin
                $display("%0t: pos_x expected %0d got %0d", $time,
                         $signed(want.pos_x), $signed(got.pos_x));
                mismatches++;
            end
            if (got.pos_y !== want.pos_y) begin
                $display("%0t: pos_y expected %0d got %0d", $time,
                         $signed(want.pos_y), $signed(got.pos_y));
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.fire !== want.fire) begin
                $display("%0t: fire expected %0d got %0d", $time, want.fire, got.fire);
                mismatches++;
            end
        endfunction
    endclass

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    logic signed [dsst_pkg::ERR_W-1:0]     s_err_x;
    logic signed [dsst_pkg::ERR_W-1:0]     s_err_y;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [dsst_pkg::PX_W-1:0]      m_pos_x;
    logic signed [dsst_pkg::PY_W-1:0]      m_pos_y;
    logic [dsst_pkg::STATUS_W-1:0]         m_status;
    logic                                  m_fire;
    logic                                  cfg_wr_en;
    logic [dsst_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [dsst_pkg::CFG_DATA_W-1:0]       cfg_wdata;

    servo_track_scoreboard sb;
    int tx_idle_pct  = 22;
    int rx_stall_pct = 65;

    two_axis_deadband_servo_tracker_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_err_x   (s_err_x),
        .s_err_y   (s_err_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pos_x   (m_pos_x),
        .m_pos_y   (m_pos_y),
        .m_status  (m_status),
        .m_fire    (m_fire),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic cfg_write(logic [dsst_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[dsst_pkg::CFG_DATA_W-1:0];
        @(posedge aclk);
        sb.write_reg(idx, val[dsst_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic program_regs(int unsigned xth, int unsigned yth, int unsigned db,
                                int unsigned xfg, int unsigned xng, int unsigned yfg,
                                int unsigned yng, int unsigned st);
        cfg_write(dsst_pkg::REG_X_FAR_TH, xth);
        cfg_write(dsst_pkg::REG_Y_FAR_TH, yth);
        cfg_write(dsst_pkg::REG_DEADBAND, db);
        cfg_write(dsst_pkg::REG_X_FAR_G, xfg);
        cfg_write(dsst_pkg::REG_X_NEAR_G, xng);
        cfg_write(dsst_pkg::REG_Y_FAR_G, yfg);
        cfg_write(dsst_pkg::REG_Y_NEAR_G, yng);
        cfg_write(dsst_pkg::REG_SETTLE, st);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_random(int db_hi, int st_hi);
        program_regs($urandom_range(0, 120), $urandom_range(0, 120), $urandom_range(0, db_hi),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(1, st_hi));
    endtask

    task automatic send_item(int ex, int ey);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_err_x <= dsst_pkg::ERR_W'(ex);
        s_err_y <= dsst_pkg::ERR_W'(ey);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(dsst_pkg::ERR_W'(ex), dsst_pkg::ERR_W'(ey));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    function automatic int pick_err(err_kind_t kind, int far_th);
        int lim, m;
        case (kind)
            ERR_IN_DB: begin
                lim = ERR_WIN;
                if (int'(sb.dead_band) < lim) lim = int'(sb.dead_band);
                if (far_th < lim) lim = far_th;
                m = int'($urandom_range(0, lim));
                return $urandom_range(0, 1) ? -m : m;
            end
            ERR_IN_WIN: return int'($urandom_range(0, 2 * ERR_WIN)) - ERR_WIN;
            default:    return int'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic err_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return ERR_IN_DB;
        if (r < 80) return ERR_IN_WIN;
        return ERR_FULL;
    endfunction

    // centered runs build the settle count; sparse out-of-range items keep it
    task automatic run_random(int n);
        int sent, run_len;
        bit paused;
        sent = 0;
        paused = 1'b0;
        while (sent < n) begin
            if (!paused && sent >= n / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 45) begin
                run_len = $urandom_range(1, sb.settle_tgt + 3);
                repeat (run_len) begin
                    if ($urandom_range(0, 99) < 8)
                        send_item(pick_err(ERR_FULL, 0), pick_err(ERR_FULL, 0));
                    else
                        send_item(pick_err(ERR_IN_DB, sb.x_far_th),
                                  pick_err(ERR_IN_DB, sb.y_far_th));
                    sent++;
                end
            end else begin
                send_item(pick_err(pick_kind(), sb.x_far_th), pick_err(pick_kind(), sb.y_far_th));
                sent++;
            end
        end
    endtask

    initial begin
        dsst_pkg::result_t got;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.pos_x  = m_pos_x;
                got.pos_y  = m_pos_y;
                got.status = m_status;
                got.fire   = m_fire;
                sb.check_result(got);
            end
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < MAX_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_err_x   <= '0;
        s_err_y   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= dsst_pkg::REG_X_FAR_TH;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: window edges, far/near/centered bands
        send_item(-512, 0);
        send_item(511, 0);
        send_item(0, -512);
        send_item(0, 511);
        send_item(113, -113);
        send_item(112, -112);
        send_item(-112, 112);
        send_item(51, 31);
        send_item(50, 30);
        send_item(-6, 6);
        send_item(5, -5);
        send_item(-5, 5);
        send_item(0, 0);
        wait_drained();

        // zero thresholds, full gains: clamps and fire every centered item
        program_regs(0, 0, 0, 255, 255, 255, 255, 1);
        send_item(0, 0);
        send_item(112, 112);
        send_item(-112, -112);
        send_item(1, -1);
        send_item(200, 0);
        wait_drained();

        // settle target zero fires on every item, out of range too
        program_regs(511, 511, 511, 0, 0, 0, 0, 0);
        send_item(112, -112);
        send_item(-300, 5);
        wait_drained();

        // deadband above far threshold: near band empty
        program_regs(10, 10, 40, 7, 200, 9, 200, 2);
        send_item(20, -20);
        send_item(-30, 35);
        send_item(5, 5);
        send_item(3, -2);
        send_item(150, 0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                tx_idle_pct  = 22;
                rx_stall_pct = 65;
            end else if (p < 6) begin
                tx_idle_pct  = 65;
                rx_stall_pct = 22;
            end else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            case (p)
                0: program_regs(32'(dsst_pkg::RST_X_FAR_TH), 32'(dsst_pkg::RST_Y_FAR_TH),
                                32'(dsst_pkg::RST_DEADBAND), 32'(dsst_pkg::RST_X_FAR_G),
                                32'(dsst_pkg::RST_X_NEAR_G), 32'(dsst_pkg::RST_Y_FAR_G),
                                32'(dsst_pkg::RST_Y_NEAR_G), 32'(dsst_pkg::RST_SETTLE));
                2: program_random(60, 4);
                3: program_regs(511, 511, 0, 255, 255, 255, 255, 63);
                4: program_regs(0, 0, 0, 0, 0, 0, 0, 1);
                6: program_regs(511, 511, 511, $urandom_range(0, 255), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255), 63);
                default: program_random(20, 8);
            endcase
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
hdl/dsst_pkg.sv
hdl/dsst_axis_lane.sv
hdl/dsst_merge.sv
hdl/two_axis_deadband_servo_tracker_top.sv
dv/tb_top.sv
